// ===== design/csl_pkg.sv =====
// Package for the Cohen-Sutherland line clipper: coordinate width, outcode bits,
// register indexes, payload and control structs, helper functions. No dependencies.
package csl_pkg;

  localparam int CoordBits  = 10;
  localparam int CfgIdxBits = 8;
  localparam int MaxPasses  = 16;
  localparam int PassBits   = $clog2(MaxPasses + 1);

  localparam logic [3:0] OcLeft   = 4'd1;
  localparam logic [3:0] OcRight  = 4'd2;
  localparam logic [3:0] OcBottom = 4'd4;
  localparam logic [3:0] OcTop    = 4'd8;

  localparam logic [CfgIdxBits-1:0] CfgXMin = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] CfgXMax = CfgIdxBits'(1);
  localparam logic [CfgIdxBits-1:0] CfgYMin = CfgIdxBits'(2);
  localparam logic [CfgIdxBits-1:0] CfgYMax = CfgIdxBits'(3);

  localparam logic [CoordBits-1:0] RstXMin = CoordBits'(200);
  localparam logic [CoordBits-1:0] RstXMax = CoordBits'(400);
  localparam logic [CoordBits-1:0] RstYMin = CoordBits'(200);
  localparam logic [CoordBits-1:0] RstYMax = CoordBits'(400);

  typedef logic [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } csl_in_t;

  typedef struct packed {
    logic   accepted;
    coord_t clip_start_x;
    coord_t clip_start_y;
    coord_t clip_end_x;
    coord_t clip_end_y;
  } csl_out_t;

  typedef struct packed {
    coord_t x_min;
    coord_t x_max;
    coord_t y_min;
    coord_t y_max;
  } csl_win_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic mul;
    logic div_start;
    logic update;
    logic finish;
    logic accept;
  } csl_cmd_t;

  typedef struct packed {
    logic c1_zero;
    logic c2_zero;
    logic share;
    logic div_busy;
    logic out_free;
  } csl_sts_t;

  function automatic logic [3:0] outcode(coord_t x, coord_t y, csl_win_t w);
    logic [3:0] c;
    c = 4'd0;
    if (x < w.x_min) c = c | OcLeft;
    if (x > w.x_max) c = c | OcRight;
    if (y > w.y_max) c = c | OcTop;
    if (y < w.y_min) c = c | OcBottom;
    return c;
  endfunction

  function automatic coord_t mag(logic [CoordBits:0] v);
    logic [CoordBits:0] n;
    n = -v;
    return v[CoordBits] ? n[CoordBits-1:0] : v[CoordBits-1:0];
  endfunction

endpackage

// ===== design/csl_div.sv =====
// Restoring divider for the line clipper, one quotient bit per cycle.
// Depends on csl_pkg for the coordinate width.
module csl_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [2*csl_pkg::CoordBits-1:0]     num_i,
  input  logic [csl_pkg::CoordBits-1:0]       den_i,
  output logic                                busy_o,
  output logic [csl_pkg::CoordBits-1:0]       quo_o
);
  import csl_pkg::*;

  localparam int CntBits = $clog2(CoordBits + 1);

  logic                 busy_q;
  logic [CntBits-1:0]   cnt_q;
  coord_t               rem_q, lo_q, den_q;
  logic [CoordBits:0]   part, trial;

  // numerator high half is below the divisor, so the quotient fits in CoordBits
  assign part  = {rem_q, lo_q[CoordBits-1]};
  assign trial = part - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntBits'(CoordBits);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[2*CoordBits-1:CoordBits];
      lo_q  <= num_i[CoordBits-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      if (!trial[CoordBits]) begin
        rem_q <= trial[CoordBits-1:0];
        lo_q  <= {lo_q[CoordBits-2:0], 1'b1};
      end else begin
        rem_q <= part[CoordBits-1:0];
        lo_q  <= {lo_q[CoordBits-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = lo_q;

endmodule

// ===== design/csl_datapath.sv =====
// Clipper datapath: endpoint registers, outcodes, edge operand setup, multiplier,
// shared divider, endpoint update and output register. Depends on csl_pkg, csl_div.
module csl_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  csl_pkg::csl_in_t   in_data_i,
  input  csl_pkg::csl_win_t  win_i,
  input  csl_pkg::csl_cmd_t  cmd_i,
  output csl_pkg::csl_sts_t  sts_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output csl_pkg::csl_out_t  out_data_o
);
  import csl_pkg::*;

  coord_t x1_q, y1_q, x2_q, y2_q;
  logic [3:0] c1, c2, co;
  logic [CoordBits:0] diff_x, diff_y, a_s, b_s, d_s;
  coord_t e_s, fix_s;
  logic   calc_x_s;

  coord_t amag_q, bmag_q, dmag_q, e_q, fix_q;
  logic   neg_q, dzero_q, calc_x_q, sel1_q;
  logic [2*CoordBits-1:0] prod_q;
  coord_t quo;
  logic [CoordBits+1:0] sum;
  coord_t val;

  logic     out_valid_q;
  csl_out_t out_q;

  assign c1 = outcode(x1_q, y1_q, win_i);
  assign c2 = outcode(x2_q, y2_q, win_i);
  assign co = (c1 != 4'd0) ? c1 : c2;

  assign diff_x = {1'b0, x1_q} - {1'b0, x2_q};
  assign diff_y = {1'b0, y1_q} - {1'b0, y2_q};

  always_comb begin
    a_s      = diff_y;
    d_s      = diff_x;
    e_s      = y2_q;
    calc_x_s = 1'b0;
    if ((co & OcTop) != 4'd0) begin
      a_s      = diff_x;
      b_s      = {1'b0, win_i.y_max} - {1'b0, y2_q};
      d_s      = diff_y;
      e_s      = x2_q;
      fix_s    = win_i.y_max;
      calc_x_s = 1'b1;
    end else if ((co & OcBottom) != 4'd0) begin
      a_s      = diff_x;
      b_s      = {1'b0, win_i.y_min} - {1'b0, y2_q};
      d_s      = diff_y;
      e_s      = x2_q;
      fix_s    = win_i.y_min;
      calc_x_s = 1'b1;
    end else if ((co & OcRight) != 4'd0) begin
      b_s   = {1'b0, win_i.x_max} - {1'b0, x2_q};
      fix_s = win_i.x_max;
    end else begin
      b_s   = {1'b0, win_i.x_min} - {1'b0, x2_q};
      fix_s = win_i.x_min;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      amag_q   <= mag(a_s);
      bmag_q   <= mag(b_s);
      dmag_q   <= mag(d_s);
      neg_q    <= a_s[CoordBits] ^ b_s[CoordBits] ^ d_s[CoordBits];
      dzero_q  <= (d_s == '0);
      e_q      <= e_s;
      fix_q    <= fix_s;
      calc_x_q <= calc_x_s;
      sel1_q   <= (c1 != 4'd0);
    end
    if (cmd_i.mul) prod_q <= amag_q * bmag_q;
  end

  csl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (prod_q),
    .den_i   (dmag_q),
    .busy_o  (sts_o.div_busy),
    .quo_o   (quo)
  );

  assign sum = neg_q ? ({2'b00, e_q} - {2'b00, quo}) : ({2'b00, e_q} + {2'b00, quo});
  assign val = dzero_q ? e_q : sum[CoordBits-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x1_q <= in_data_i.start_x;
      y1_q <= in_data_i.start_y;
      x2_q <= in_data_i.end_x;
      y2_q <= in_data_i.end_y;
    end else if (cmd_i.update) begin
      if (sel1_q) begin
        x1_q <= calc_x_q ? val : fix_q;
        y1_q <= calc_x_q ? fix_q : val;
      end else begin
        x2_q <= calc_x_q ? val : fix_q;
        y2_q <= calc_x_q ? fix_q : val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.accepted     <= cmd_i.accept;
      out_q.clip_start_x <= cmd_i.accept ? x1_q : '0;
      out_q.clip_start_y <= cmd_i.accept ? y1_q : '0;
      out_q.clip_end_x   <= cmd_i.accept ? x2_q : '0;
      out_q.clip_end_y   <= cmd_i.accept ? y2_q : '0;
    end
  end

  assign sts_o.c1_zero  = (c1 == 4'd0);
  assign sts_o.c2_zero  = (c2 == 4'd0);
  assign sts_o.share    = ((c1 & c2) != 4'd0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/csl_ctrl.sv =====
// Clipper controller: sequences outcode test, edge setup, multiply, divide and
// endpoint update per pass, then hands the result over. Depends on csl_pkg.
module csl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  csl_pkg::csl_sts_t  sts_i,
  output csl_pkg::csl_cmd_t  cmd_o
);
  import csl_pkg::*;

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] STest   = 3'd1;
  localparam logic [2:0] SMul    = 3'd2;
  localparam logic [2:0] SDStart = 3'd3;
  localparam logic [2:0] SDiv    = 3'd4;
  localparam logic [2:0] SUpd    = 3'd5;
  localparam logic [2:0] SDone   = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [PassBits-1:0] pass_q, pass_d;
  logic                acc_q, acc_d;

  assign in_stall_o = (state_q != SIdle);

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    acc_d   = acc_q;
    cmd_o   = '0;
    cmd_o.accept = acc_q;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          pass_d     = '0;
          state_d    = STest;
        end
      end
      STest: begin
        if (sts_i.c1_zero && sts_i.c2_zero) begin
          acc_d   = 1'b1;
          state_d = SDone;
        end else if (sts_i.share || pass_q == PassBits'(MaxPasses)) begin
          acc_d   = 1'b0;
          state_d = SDone;
        end else begin
          cmd_o.setup = 1'b1;
          pass_d      = pass_q + 1'b1;
          state_d     = SMul;
        end
      end
      SMul: begin
        cmd_o.mul = 1'b1;
        state_d   = SDStart;
      end
      SDStart: begin
        cmd_o.div_start = 1'b1;
        state_d         = SDiv;
      end
      SDiv: begin
        if (!sts_i.div_busy) state_d = SUpd;
      end
      SUpd: begin
        cmd_o.update = 1'b1;
        state_d      = STest;
      end
      SDone: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      pass_q  <= '0;
      acc_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      acc_q   <= acc_d;
    end
  end

endmodule

// ===== design/cohen_sutherland_line_clipper_core.sv =====
// Cohen-Sutherland line clipper top level: window registers, controller, datapath.
// Depends on csl_pkg, csl_ctrl, csl_datapath, csl_div.
//
// Clips one segment per word against the window held in four registers
// (index 0 x_min, 1 x_max, 2 y_min, 3 y_max; other indexes are ignored).
// Each edge move steps through operand setup, multiply, divider start, the
// restoring divide that yields one quotient bit per cycle, and endpoint
// update; a segment needs at most four moves with a proper window and at
// most sixteen otherwise. A new segment is taken once the previous one
// has moved into the output register. A rejected segment reports zero
// coordinates. Window writes are taken every cycle and must only happen
// while the block is idle.
module cohen_sutherland_line_clipper_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  csl_pkg::csl_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output csl_pkg::csl_out_t                   out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [csl_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [csl_pkg::CoordBits-1:0]       cfg_data_i
);
  import csl_pkg::*;

  csl_win_t win_q;
  csl_cmd_t cmd;
  csl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q.x_min <= RstXMin;
      win_q.x_max <= RstXMax;
      win_q.y_min <= RstYMin;
      win_q.y_max <= RstYMax;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgXMin: win_q.x_min <= cfg_data_i;
        CfgXMax: win_q.x_max <= cfg_data_i;
        CfgYMin: win_q.y_min <= cfg_data_i;
        CfgYMax: win_q.y_max <= cfg_data_i;
        default: ;
      endcase
    end
  end

  csl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  csl_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .win_i       (win_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
